FILE: rtl/taj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_pkg
// Types, sizes and codes shared by the tree ancestor jump table block.
// ----------------------------------------------------------------------------
package taj_pkg;

  localparam int unsigned NODES  = 1024;
  localparam int unsigned LEVELS = 10;

  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CNT_W  = NODE_W + 1;
  localparam int unsigned JA_W   = LVL_W + NODE_W;
  localparam int unsigned JDEPTH = NODES * LEVELS;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned FLD_W  = 10;
  localparam int unsigned TIME_W = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned KW     = (LEVELS > FLD_W) ? LEVELS : FLD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_KTH   = 2'd2,
    CMD_LCA   = 2'd3
  } taj_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_A,
    ST_BLD_B,
    ST_BLD_C,
    ST_KTH,
    ST_KTH_USE,
    ST_LCA_TU,
    ST_LCA_TV,
    ST_LCA_UV,
    ST_LCA_VU,
    ST_LCA_JMP,
    ST_LCA_W,
    ST_LCA_CMP,
    ST_LCA_FIN,
    ST_LCA_END,
    ST_RESULT
  } taj_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] entry;
    logic [TIME_W-1:0] exit_t;
  } taj_times_t;

  typedef struct packed {
    logic              we;
    logic [JA_W-1:0]   waddr;
    logic [NODE_W-1:0] wdata;
    logic [JA_W-1:0]   raddr;
  } taj_jmp_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    taj_times_t        wdata;
    logic [NODE_W-1:0] raddr;
  } taj_tim_req_t;

  function automatic logic [JA_W-1:0] jaddr(logic [LVL_W-1:0] lvl, logic [NODE_W-1:0] node);
    return {lvl, node};
  endfunction

  function automatic logic [NODE_W-1:0] wrap_node(logic [FLD_W-1:0] n);
    logic [31:0] wide;
    wide = 32'(n);
    return wide[NODE_W-1:0];
  endfunction

endpackage

FILE: rtl/taj_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_if
// Valid/ready channels of the jump table: configuration, query and answer.
// ----------------------------------------------------------------------------
interface taj_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [taj_pkg::CFG_W-1:0] node_count;

  modport source (output valid, output node_count, input ready);
  modport sink   (input valid, input node_count, output ready);
endinterface

interface taj_in_if;
  logic                       valid;
  logic                       ready;
  logic [taj_pkg::CMD_W-1:0]  cmd;
  logic [taj_pkg::FLD_W-1:0]  node;
  logic [taj_pkg::FLD_W-1:0]  other_node;
  logic [taj_pkg::FLD_W-1:0]  steps_up;
  logic [taj_pkg::TIME_W-1:0] entry_time;
  logic [taj_pkg::TIME_W-1:0] exit_time;

  modport source (output valid, output cmd, output node, output other_node,
                  output steps_up, output entry_time, output exit_time, input ready);
  modport sink   (input valid, input cmd, input node, input other_node,
                  input steps_up, input entry_time, input exit_time, output ready);
endinterface

interface taj_out_if;
  logic                      valid;
  logic                      ready;
  logic [taj_pkg::FLD_W-1:0] answer_node;

  modport source (output valid, output answer_node, input ready);
  modport sink   (input valid, input answer_node, output ready);
endinterface

FILE: rtl/tree_ancestor_jump_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_jump_table
// Binary-lifting ancestor table with k-th ancestor and common ancestor queries.
// ----------------------------------------------------------------------------
// Load beats carry a parent plus Euler-tour times. A build beat covers
// n = min(node_count, NODES) nodes; each table entry needs two dependent reads
// and a write on the single jump table read port. K-th ancestor and common
// ancestor queries are paced by the dependent reads through the jump table
// and time memories; a common ancestor query on equal nodes skips the walk.
// The block takes one beat at a time; a finished answer sits in an output
// register so the next beat can be taken while it waits. The tables have no
// reset: query only nodes that have been loaded and built.
// ----------------------------------------------------------------------------
module tree_ancestor_jump_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  taj_cfg_if.sink    cfg_i,
  taj_in_if.sink     in_i,
  taj_out_if.source  out_o
);

  logic [taj_pkg::CFG_W-1:0]  node_count_q;
  taj_pkg::taj_jmp_req_t      jmp_req;
  taj_pkg::taj_tim_req_t      tim_req;
  logic [taj_pkg::NODE_W-1:0] jmp_rdata;
  taj_pkg::taj_times_t        tim_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= taj_pkg::CFG_W'(1);
    end else if (cfg_i.valid) begin
      node_count_q <= cfg_i.node_count;
    end
  end

  taj_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .jmp_req_o    (jmp_req),
    .jmp_rdata_i  (jmp_rdata),
    .tim_req_o    (tim_req),
    .tim_rdata_i  (tim_rdata)
  );

  taj_ram #(
    .WIDTH (taj_pkg::NODE_W),
    .DEPTH (taj_pkg::JDEPTH)
  ) u_jmp_ram (
    .clk_i   (clk_i),
    .we_i    (jmp_req.we),
    .waddr_i (jmp_req.waddr),
    .wdata_i (jmp_req.wdata),
    .raddr_i (jmp_req.raddr),
    .rdata_o (jmp_rdata)
  );

  taj_ram #(
    .WIDTH (2 * taj_pkg::TIME_W),
    .DEPTH (taj_pkg::NODES)
  ) u_tim_ram (
    .clk_i   (clk_i),
    .we_i    (tim_req.we),
    .waddr_i (tim_req.waddr),
    .wdata_i (tim_req.wdata),
    .raddr_i (tim_req.raddr),
    .rdata_o (tim_rdata)
  );

endmodule

FILE: rtl/taj_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module taj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/taj_anc_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_anc_cmp
// Strict ancestor test on Euler-tour times: anc encloses desc on both ends.
// ----------------------------------------------------------------------------
module taj_anc_cmp (
  input  taj_pkg::taj_times_t anc_i,
  input  taj_pkg::taj_times_t desc_i,
  output logic                is_anc_o
);

  assign is_anc_o = (desc_i.entry > anc_i.entry) && (anc_i.exit_t > desc_i.exit_t);

endmodule

FILE: rtl/taj_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_seq
// Sequencer: loads, table build, k-th ancestor climb and common ancestor walk
// over the shared table read port and one ancestor comparator.
// ----------------------------------------------------------------------------
module taj_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [taj_pkg::CFG_W-1:0]     node_count_i,
  taj_in_if.sink                        in_i,
  taj_out_if.source                     out_o,
  output taj_pkg::taj_jmp_req_t         jmp_req_o,
  input  logic [taj_pkg::NODE_W-1:0]    jmp_rdata_i,
  output taj_pkg::taj_tim_req_t         tim_req_o,
  input  taj_pkg::taj_times_t           tim_rdata_i
);

  localparam logic [taj_pkg::LVL_W-1:0] LVL_TOP  = taj_pkg::LVL_W'(taj_pkg::LEVELS - 1);
  localparam logic [taj_pkg::LVL_W-1:0] LVL_ZERO = '0;
  localparam logic [taj_pkg::LVL_W-1:0] LVL_ONE  = taj_pkg::LVL_W'(1);

  taj_pkg::taj_state_e            state_q, state_d;
  logic [taj_pkg::NODE_W-1:0]     v_q, v_d;
  logic [taj_pkg::NODE_W-1:0]     u_q, u_d;
  logic [taj_pkg::NODE_W-1:0]     w_q, w_d;
  logic [taj_pkg::NODE_W-1:0]     i_q, i_d;
  logic [taj_pkg::CNT_W-1:0]      n_q, n_d;
  logic [taj_pkg::LVL_W-1:0]      lvl_q, lvl_d;
  logic [taj_pkg::KW-1:0]         k_q, k_d;
  logic [taj_pkg::NODE_W-1:0]     ans_q, ans_d;
  taj_pkg::taj_times_t            tu_q, tu_d;
  taj_pkg::taj_times_t            tv_q, tv_d;
  logic                           out_valid_q, out_valid_d;
  logic [taj_pkg::NODE_W-1:0]     out_node_q, out_node_d;

  taj_pkg::taj_times_t            cmp_anc, cmp_desc;
  logic                           is_anc;
  logic                           accept;
  logic [taj_pkg::NODE_W-1:0]     in_v, in_u;
  logic [taj_pkg::CNT_W-1:0]      n_clamp;
  logic                           last_node;

  taj_anc_cmp u_cmp (
    .anc_i    (cmp_anc),
    .desc_i   (cmp_desc),
    .is_anc_o (is_anc)
  );

  assign in_i.ready        = (state_q == taj_pkg::ST_IDLE);
  assign accept            = in_i.valid && in_i.ready;
  assign in_v              = taj_pkg::wrap_node(in_i.node);
  assign in_u              = taj_pkg::wrap_node(in_i.other_node);
  assign out_o.valid       = out_valid_q;
  assign out_o.answer_node = taj_pkg::FLD_W'(out_node_q);
  assign last_node         = ({1'b0, i_q} + taj_pkg::CNT_W'(1)) == n_q;

  always_comb begin
    if (32'(node_count_i) >= 32'(taj_pkg::NODES)) begin
      n_clamp = taj_pkg::CNT_W'(taj_pkg::NODES);
    end else begin
      n_clamp = taj_pkg::CNT_W'(node_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= taj_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    u_q        <= u_d;
    w_q        <= w_d;
    i_q        <= i_d;
    n_q        <= n_d;
    lvl_q      <= lvl_d;
    k_q        <= k_d;
    ans_q      <= ans_d;
    tu_q       <= tu_d;
    tv_q       <= tv_d;
    out_node_q <= out_node_d;
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    u_d         = u_q;
    w_d         = w_q;
    i_d         = i_q;
    n_d         = n_q;
    lvl_d       = lvl_q;
    k_d         = k_q;
    ans_d       = ans_q;
    tu_d        = tu_q;
    tv_d        = tv_q;
    out_node_d  = out_node_q;
    out_valid_d = out_valid_q && !out_o.ready;
    jmp_req_o   = '0;
    tim_req_o   = '0;
    cmp_anc     = tu_q;
    cmp_desc    = tim_rdata_i;

    unique case (state_q)
      taj_pkg::ST_IDLE: begin
        if (accept) begin
          v_d   = in_v;
          u_d   = in_u;
          k_d   = taj_pkg::KW'(in_i.steps_up);
          lvl_d = LVL_TOP;
          case (taj_pkg::taj_cmd_e'(in_i.cmd))
            taj_pkg::CMD_LOAD: begin
              jmp_req_o.we          = 1'b1;
              jmp_req_o.waddr       = taj_pkg::jaddr(LVL_ZERO, in_v);
              jmp_req_o.wdata       = in_u;
              tim_req_o.we          = 1'b1;
              tim_req_o.waddr       = in_v;
              tim_req_o.wdata.entry  = in_i.entry_time;
              tim_req_o.wdata.exit_t = in_i.exit_time;
            end
            taj_pkg::CMD_BUILD: begin
              n_d   = n_clamp;
              i_d   = '0;
              lvl_d = LVL_ONE;
              if (n_clamp != '0 && taj_pkg::LEVELS > 1) begin
                state_d = taj_pkg::ST_BLD_A;
              end
            end
            taj_pkg::CMD_KTH: begin
              state_d = taj_pkg::ST_KTH;
            end
            default: begin
              if (in_v == in_u) begin
                ans_d   = in_v;
                state_d = taj_pkg::ST_RESULT;
              end else begin
                state_d = taj_pkg::ST_LCA_TU;
              end
            end
          endcase
        end
      end

      // build: jump(i, lvl) = jump(jump(i, lvl-1), lvl-1)
      taj_pkg::ST_BLD_A: begin
        jmp_req_o.raddr = taj_pkg::jaddr(lvl_q - LVL_ONE, i_q);
        state_d         = taj_pkg::ST_BLD_B;
      end
      taj_pkg::ST_BLD_B: begin
        jmp_req_o.raddr = taj_pkg::jaddr(lvl_q - LVL_ONE, jmp_rdata_i);
        state_d         = taj_pkg::ST_BLD_C;
      end
      taj_pkg::ST_BLD_C: begin
        jmp_req_o.we    = 1'b1;
        jmp_req_o.waddr = taj_pkg::jaddr(lvl_q, i_q);
        jmp_req_o.wdata = jmp_rdata_i;
        state_d         = taj_pkg::ST_BLD_A;
        if (last_node) begin
          i_d = '0;
          if (lvl_q == LVL_TOP) begin
            state_d = taj_pkg::ST_IDLE;
          end else begin
            lvl_d = lvl_q + LVL_ONE;
          end
        end else begin
          i_d = i_q + taj_pkg::NODE_W'(1);
        end
      end

      // k-th ancestor: hop on set bits, top level first
      taj_pkg::ST_KTH: begin
        if (k_q[lvl_q]) begin
          jmp_req_o.raddr = taj_pkg::jaddr(lvl_q, v_q);
          state_d         = taj_pkg::ST_KTH_USE;
        end else if (lvl_q == LVL_ZERO) begin
          ans_d   = v_q;
          state_d = taj_pkg::ST_RESULT;
        end else begin
          lvl_d = lvl_q - LVL_ONE;
        end
      end
      taj_pkg::ST_KTH_USE: begin
        v_d = jmp_rdata_i;
        if (lvl_q == LVL_ZERO) begin
          ans_d   = jmp_rdata_i;
          state_d = taj_pkg::ST_RESULT;
        end else begin
          lvl_d   = lvl_q - LVL_ONE;
          state_d = taj_pkg::ST_KTH;
        end
      end

      // common ancestor
      taj_pkg::ST_LCA_TU: begin
        tim_req_o.raddr = u_q;
        state_d         = taj_pkg::ST_LCA_TV;
      end
      taj_pkg::ST_LCA_TV: begin
        tu_d            = tim_rdata_i;
        tim_req_o.raddr = v_q;
        state_d         = taj_pkg::ST_LCA_UV;
      end
      taj_pkg::ST_LCA_UV: begin
        tv_d     = tim_rdata_i;
        cmp_anc  = tu_q;
        cmp_desc = tim_rdata_i;
        if (is_anc) begin
          ans_d   = u_q;
          state_d = taj_pkg::ST_RESULT;
        end else begin
          state_d = taj_pkg::ST_LCA_VU;
        end
      end
      taj_pkg::ST_LCA_VU: begin
        cmp_anc  = tv_q;
        cmp_desc = tu_q;
        if (is_anc) begin
          ans_d   = v_q;
          state_d = taj_pkg::ST_RESULT;
        end else begin
          lvl_d   = LVL_TOP;
          state_d = taj_pkg::ST_LCA_JMP;
        end
      end
      taj_pkg::ST_LCA_JMP: begin
        jmp_req_o.raddr = taj_pkg::jaddr(lvl_q, v_q);
        state_d         = taj_pkg::ST_LCA_W;
      end
      taj_pkg::ST_LCA_W: begin
        w_d             = jmp_rdata_i;
        tim_req_o.raddr = jmp_rdata_i;
        state_d         = taj_pkg::ST_LCA_CMP;
      end
      taj_pkg::ST_LCA_CMP: begin
        cmp_anc  = tim_rdata_i;
        cmp_desc = tu_q;
        if (!is_anc) begin
          v_d = w_q;
        end
        if (lvl_q == LVL_ZERO) begin
          state_d = taj_pkg::ST_LCA_FIN;
        end else begin
          lvl_d   = lvl_q - LVL_ONE;
          state_d = taj_pkg::ST_LCA_JMP;
        end
      end
      taj_pkg::ST_LCA_FIN: begin
        jmp_req_o.raddr = taj_pkg::jaddr(LVL_ZERO, v_q);
        state_d         = taj_pkg::ST_LCA_END;
      end
      taj_pkg::ST_LCA_END: begin
        ans_d   = jmp_rdata_i;
        state_d = taj_pkg::ST_RESULT;
      end

      // hand over to the output register once it is free
      taj_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_node_d  = ans_q;
          state_d     = taj_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = taj_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/taj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taj_checker
// Port-level checks of the jump table: answer channel and sequencing of beats.
// ----------------------------------------------------------------------------
module taj_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [taj_pkg::CMD_W-1:0] in_cmd_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [taj_pkg::FLD_W-1:0] out_answer_i
);

  logic in_beat;
  logic query_beat;

  assign in_beat    = in_valid_i && in_ready_i;
  assign query_beat = in_beat && ((in_cmd_i == taj_pkg::CMD_KTH) ||
                                  (in_cmd_i == taj_pkg::CMD_LCA));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("answer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_answer_i))
    else $error("answer changed while stalled");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_beat |=> !in_ready_i)
    else $error("query beat did not occupy the block");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_cmd_i == taj_pkg::CMD_LOAD) |=> in_ready_i)
    else $error("load beat stalled the input");

endmodule

bind tree_ancestor_jump_table taj_checker u_taj_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_answer_i (out_o.answer_node)
);
